### sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared word types, action and status codes and size defaults.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DATA_W    = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 5;
  localparam int DEPTH_DEF = 16;

  // Action codes carried in the input word.
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd4;

  // Status codes carried in the result word.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;
  } out_word_t;

endpackage

### sv/bdq_chan_if.sv
// ----------------------------------------------------------------------------
// Bounded deque channel interface
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface bdq_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### sv/bounded_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue of signed 32-bit values in a ring store, with value search.
// ----------------------------------------------------------------------------
// Sequencing: a push, pop or undefined action passes from idle to S_RESP, which
// loads the result word into the output register; the next word is taken only
// back in idle. A search compares entries in S_SRCH (up to and including the
// first match, at most the fill count) before S_RESP; a held output register
// stalls S_RESP.
// Reset clears the sequencer, front index, fill count and output valid only.
module bounded_deque_with_search_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bdq_chan_if.sink    in_ch,
  bdq_chan_if.source  out_ch
);

  // Index width into the ring, and count width wide enough to hold DEPTH.
  localparam int IW = $clog2(DEPTH);
  localparam int CW = IW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_RESP
  } state_t;

  state_t                          st_r, st_nxt;
  logic [IW-1:0]                   front_r, front_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [IW-1:0]                   ptr_r, ptr_nxt;
  logic [CW-1:0]                   k_r, k_nxt;
  logic signed [bdq_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [bdq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  bdq_pkg::out_word_t              out_word_r, out_word_nxt;

  logic                            accept;
  logic                            full;
  logic                            empty;
  logic [IW-1:0]                   front_dec;
  logic [IW-1:0]                   front_inc;
  logic [IW-1:0]                   ptr_inc;
  logic [CW-1:0]                   back_sum;
  logic [CW-1:0]                   back_pos;

  logic                            wr_en;
  logic [IW-1:0]                   wr_addr;
  logic [bdq_pkg::DATA_W-1:0]      wr_data;
  logic                            rd_en;
  logic [IW-1:0]                   rd_addr;
  logic [bdq_pkg::DATA_W-1:0]      rd_data;

  // Reads are issued only for a search and writes only for a push, and one
  // word is worked on at a time, so a read never overlaps a write.
  bdq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_word_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Ring arithmetic: step with wrap, and the slot just past the back entry.
  // The back sum stays below twice DEPTH, so one compare and subtract wraps it.
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign ptr_inc   = (ptr_r == IW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign back_sum  = {1'b0, front_r} + count_r;
  assign back_pos  = (back_sum >= CW'(DEPTH)) ? back_sum - CW'(DEPTH) : back_sum;

  always_comb begin
    st_nxt        = st_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;

    wr_en   = 1'b0;
    wr_addr = back_pos[IW-1:0];
    wr_data = in_ch.payload.value;
    rd_en   = 1'b0;
    rd_addr = ptr_r;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt  = in_ch.payload.value;
          status_nxt = bdq_pkg::ST_OK;
          st_nxt     = S_RESP;
          unique case (in_ch.payload.action)
            bdq_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                status_nxt = bdq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                status_nxt = bdq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              if (empty) begin
                status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                front_nxt = front_inc;
                count_nxt = count_r - 1'b1;
              end
            end
            bdq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            bdq_pkg::ACT_SEARCH: begin
              if (empty) begin
                status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                // Fetch the front entry now; it is compared next cycle.
                rd_en   = 1'b1;
                rd_addr = front_r;
                ptr_nxt = front_inc;
                k_nxt   = '0;
                st_nxt  = S_SRCH;
              end
            end
            default: begin
              // Undefined actions leave the queue alone and report done.
            end
          endcase
        end
      end

      S_SRCH: begin
        // Entry k arrives from the store while entry k + 1 is being fetched.
        if (rd_data == value_r) begin
          status_nxt = bdq_pkg::ST_OK;
          st_nxt     = S_RESP;
        end else if (k_r == count_r - 1'b1) begin
          status_nxt = bdq_pkg::ST_NOT_FOUND;
          st_nxt     = S_RESP;
        end else begin
          k_nxt   = k_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = ptr_r;
          ptr_nxt = ptr_inc;
        end
      end

      S_RESP: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.status     = status_r;
          out_word_nxt.fill_count = bdq_pkg::FILL_W'(count_r);
          st_nxt                  = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    k_r        <= k_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The fill count never passes the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count exceeds ring size");

  // An accepted word always moves the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (st_r != S_IDLE))
    else $error("accepted word did not start work");

  // A search never compares beyond the held entries.
  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SRCH) |-> (k_r < count_r))
    else $error("search index past held entries");

  // The queue changes only as a direct effect of an accepted word.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(accept)) |-> ($stable(count_r) && $stable(front_r)))
    else $error("queue state changed without an accepted word");

endmodule

### sv/bdq_store.sv
// ----------------------------------------------------------------------------
// Bounded deque entry store
// Ring storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [bdq_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [bdq_pkg::DATA_W-1:0] rd_data
);

  logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
